FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers with clock and active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/lbpg_pkg.sv
// ----------------------------------------------------------------------------
// LED blink pattern generator package
// Types, codes and constants shared by the pattern generator files.
// ----------------------------------------------------------------------------
package lbpg_pkg;

  // Command codes of an input item.
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SELECT = 2'd1,
    OP_LEVEL  = 2'd2,
    OP_ENABLE = 2'd3
  } op_e;

  // Pattern codes.
  typedef enum logic [3:0] {
    PAT_OFF        = 4'd0,
    PAT_STATIC_OFF = 4'd1,
    PAT_STATIC_ON  = 4'd2,
    PAT_STARTUP    = 4'd3,
    PAT_ERROR      = 4'd4,
    PAT_NET_OK     = 4'd5,
    PAT_NET_FAIL   = 4'd6,
    PAT_WARNING    = 4'd7,
    PAT_ALARM      = 4'd8,
    PAT_LEVEL      = 4'd9
  } pattern_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_LIT_HIGH   = 3'd0,
    CFG_STARTUP_MS = 3'd1,
    CFG_ERROR_MS   = 3'd2,
    CFG_NETFAIL_MS = 3'd3,
    CFG_WARNING_MS = 3'd4,
    CFG_ALARM_MS   = 3'd5
  } cfg_idx_e;

  localparam int unsigned MsW  = 16;
  localparam int unsigned PhW  = 3;
  localparam int unsigned DutyW = 8;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [PhW-1:0] ErrorPhases   = 3'd6;
  localparam logic [PhW-1:0] WarningPhases = 3'd4;
  localparam logic [MsW-1:0] MsMax         = 16'hFFFF;

  // One input item.
  typedef struct packed {
    op_e              operation;
    logic [3:0]       pattern_code;
    logic [DutyW-1:0] level_value;
    logic             enable_value;
  } item_t;

  // One result item.
  typedef struct packed {
    logic             pin_level;
    logic             pwm_active;
    logic [DutyW-1:0] pwm_duty;
    logic [3:0]       current_pattern;
    logic             is_enabled;
  } result_t;

  // Configuration register set.
  typedef struct packed {
    logic           lit_high;
    logic [MsW-1:0] startup_pulse_ms;
    logic [MsW-1:0] error_half_ms;
    logic [MsW-1:0] netfail_half_ms;
    logic [MsW-1:0] warning_half_ms;
    logic [MsW-1:0] alarm_half_ms;
  } cfg_t;

  // Indicator state.
  typedef struct packed {
    pattern_e         pattern_reg;
    logic             led_on;
    logic             pwm_on;
    logic [DutyW-1:0] duty_reg;
    logic             enabled_reg;
    logic [PhW-1:0]   phase_count;
    logic             burst_done;
    logic [MsW-1:0]   ms_since_toggle;
  } state_t;

endpackage

FILE: sv/lbpg_in_if.sv
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface lbpg_in_if;
  import lbpg_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       operation;
  logic [3:0]       pattern_code;
  logic [DutyW-1:0] level_value;
  logic             enable_value;

  modport source (output valid, operation, pattern_code, level_value, enable_value,
                  input ready);
  modport sink (input valid, operation, pattern_code, level_value, enable_value,
                output ready);
endinterface

FILE: sv/lbpg_out_if.sv
// ----------------------------------------------------------------------------
// Status channel
// Valid/ready channel carrying one status result.
// ----------------------------------------------------------------------------
interface lbpg_out_if;
  import lbpg_pkg::*;

  logic             valid;
  logic             ready;
  logic             pin_level;
  logic             pwm_active;
  logic [DutyW-1:0] pwm_duty;
  logic [3:0]       current_pattern;
  logic             is_enabled;

  modport source (output valid, pin_level, pwm_active, pwm_duty, current_pattern,
                  is_enabled, input ready);
  modport sink (input valid, pin_level, pwm_active, pwm_duty, current_pattern,
                is_enabled, output ready);
endinterface

FILE: sv/lbpg_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface lbpg_cfg_if;
  import lbpg_pkg::*;

  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [MsW-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/lbpg_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Polarity and timing registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module lbpg_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  lbpg_cfg_if.sink       cfg_i,
  output lbpg_pkg::cfg_t cfg_o
);
  import lbpg_pkg::*;

  cfg_t cfg_q;

  // Writes are always taken; an unknown index is dropped.
  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lit_high         <= 1'b1;
      cfg_q.startup_pulse_ms <= 16'd200;
      cfg_q.error_half_ms    <= 16'd100;
      cfg_q.netfail_half_ms  <= 16'd500;
      cfg_q.warning_half_ms  <= 16'd200;
      cfg_q.alarm_half_ms    <= 16'd50;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_LIT_HIGH:   cfg_q.lit_high         <= cfg_i.data[0];
        CFG_STARTUP_MS: cfg_q.startup_pulse_ms <= cfg_i.data;
        CFG_ERROR_MS:   cfg_q.error_half_ms    <= cfg_i.data;
        CFG_NETFAIL_MS: cfg_q.netfail_half_ms  <= cfg_i.data;
        CFG_WARNING_MS: cfg_q.warning_half_ms  <= cfg_i.data;
        CFG_ALARM_MS:   cfg_q.alarm_half_ms    <= cfg_i.data;
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/lbpg_fsm.sv
// ----------------------------------------------------------------------------
// Indicator state machine
// Holds the LED state and computes the next state and status for one command.
// ----------------------------------------------------------------------------
module lbpg_fsm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  lbpg_pkg::item_t   item_i,
  input  lbpg_pkg::cfg_t    cfg_i,
  output lbpg_pkg::result_t res_o,
  output lbpg_pkg::state_t  state_o
);
  import lbpg_pkg::*;

  state_t st_q, st_d;

  // Light on even phase, dark on odd phase, advance the phase, restart timing.
  function automatic state_t toggle_parity(state_t s);
    state_t r;
    r                 = s;
    r.led_on          = ~s.phase_count[0];
    r.pwm_on          = 1'b0;
    r.phase_count     = s.phase_count + 3'd1;
    r.ms_since_toggle = '0;
    return r;
  endfunction

  // Next state for the command in the input register.
  always_comb begin
    logic [MsW-1:0] ms_inc;
    logic [MsW-1:0] half;
    logic [PhW-1:0] phases;
    logic           elapsed;

    st_d    = st_q;
    ms_inc  = (st_q.ms_since_toggle < MsMax) ? st_q.ms_since_toggle + 16'd1
                                               : st_q.ms_since_toggle;
    // Timing register that applies to the current pattern.
    case (st_q.pattern_reg)
      PAT_STARTUP:  half = cfg_i.startup_pulse_ms;
      PAT_ERROR:    half = cfg_i.error_half_ms;
      PAT_WARNING:  half = cfg_i.warning_half_ms;
      PAT_NET_FAIL: half = cfg_i.netfail_half_ms;
      PAT_ALARM:    half = cfg_i.alarm_half_ms;
      default:      half = cfg_i.alarm_half_ms;
    endcase
    phases  = (st_q.pattern_reg == PAT_ERROR) ? ErrorPhases : WarningPhases;
    elapsed = (ms_inc >= half);

    case (item_i.operation)
      OP_TICK: begin
        st_d.ms_since_toggle = ms_inc;
        if (st_q.enabled_reg) begin
          case (st_q.pattern_reg)
            PAT_STARTUP: begin
              if (st_q.phase_count == 3'd0) begin
                st_d.led_on          = 1'b1;
                st_d.pwm_on          = 1'b0;
                st_d.ms_since_toggle = '0;
                st_d.phase_count     = 3'd1;
              end else if (st_q.phase_count == 3'd1 && elapsed) begin
                st_d.led_on      = 1'b0;
                st_d.pwm_on      = 1'b0;
                st_d.phase_count = 3'd2;
              end
            end
            PAT_ERROR, PAT_WARNING: begin
              if (!st_q.burst_done && elapsed) begin
                st_d = toggle_parity(st_d);
                if (st_d.phase_count >= phases) begin
                  st_d.phase_count = '0;
                  st_d.burst_done  = 1'b1;
                  st_d.led_on      = 1'b0;
                end
              end
            end
            PAT_NET_FAIL, PAT_ALARM: begin
              if (elapsed) begin
                st_d = toggle_parity(st_d);
              end
            end
            default: ;
          endcase
        end
      end
      OP_SELECT: begin
        if (item_i.pattern_code <= PAT_LEVEL) begin
          st_d.pattern_reg     = pattern_e'(item_i.pattern_code);
          st_d.phase_count     = '0;
          st_d.burst_done      = 1'b0;
          st_d.ms_since_toggle = '0;
          st_d.pwm_on          = 1'b0;
          case (pattern_e'(item_i.pattern_code))
            PAT_OFF, PAT_STATIC_OFF: st_d.led_on = 1'b0;
            PAT_STATIC_ON, PAT_NET_OK: st_d.led_on = 1'b1;
            PAT_NET_FAIL: begin
              st_d.led_on      = 1'b1;
              st_d.phase_count = 3'd1;
            end
            PAT_LEVEL: st_d.pwm_on = 1'b1;
            default: ;
          endcase
        end
      end
      OP_LEVEL: begin
        st_d.duty_reg = item_i.level_value;
        if (st_q.pattern_reg == PAT_LEVEL && st_q.enabled_reg) begin
          st_d.pwm_on = 1'b1;
        end
      end
      OP_ENABLE: begin
        st_d.enabled_reg = item_i.enable_value;
        if (!item_i.enable_value) begin
          st_d.led_on = 1'b0;
          st_d.pwm_on = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Status after the command, with polarity applied to the pin.
  always_comb begin
    res_o.pin_level       = st_d.pwm_on ? 1'b0 : (st_d.led_on ~^ cfg_i.lit_high);
    res_o.pwm_active      = st_d.pwm_on;
    res_o.pwm_duty        = st_d.duty_reg;
    res_o.current_pattern = st_d.pattern_reg;
    res_o.is_enabled      = st_d.enabled_reg;
  end

  // State register, updated when the command moves to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.pattern_reg     <= PAT_OFF;
      st_q.led_on          <= 1'b0;
      st_q.pwm_on          <= 1'b0;
      st_q.duty_reg        <= '0;
      st_q.enabled_reg     <= 1'b1;
      st_q.phase_count     <= '0;
      st_q.burst_done      <= 1'b0;
      st_q.ms_since_toggle <= '0;
    end else if (advance_i) begin
      st_q <= st_d;
    end
  end

  assign state_o = st_q;

endmodule

FILE: sv/led_blink_pattern_generator_unit.sv
// ----------------------------------------------------------------------------
// LED blink pattern generator
// Status LED driver: commands in, one status result out per command.
// ----------------------------------------------------------------------------
//   Channel  Dir  Transfer moves
//   in_i     in   operation, pattern_code, level_value, enable_value
//   out_o    out  pin_level, pwm_active, pwm_duty, current_pattern, is_enabled
//   cfg_i    in   index, data (register write)
//
// One command per cycle is sustained while out_o.ready stays high; each command
// passes the input register, then the result register, before its result is valid.
// The state update is a single increment, compare and select between the two.
// Reset (rst_ni low) restores the default pattern state and timing registers.
// A stalled result holds the result register; the input register then takes
// one more command before in_i.ready drops.
`include "assert_macros.svh"

module led_blink_pattern_generator_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  lbpg_in_if.sink   in_i,
  lbpg_out_if.source out_o,
  lbpg_cfg_if.sink  cfg_i
);
  import lbpg_pkg::*;

  cfg_t    cfg;
  result_t res;
  state_t  st;

  logic    s1_valid_q, s1_valid_d;
  item_t   s1_item_q;
  logic    out_valid_q, out_valid_d;
  result_t out_res_q;
  logic    out_free;
  logic    s1_adv;
  logic    in_xfer;

  // Handshake: the input register moves on when the result register is free.
  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_xfer    = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input and result payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q.operation    <= op_e'(in_i.operation);
      s1_item_q.pattern_code <= in_i.pattern_code;
      s1_item_q.level_value  <= in_i.level_value;
      s1_item_q.enable_value <= in_i.enable_value;
    end
    if (s1_adv) begin
      out_res_q <= res;
    end
  end

  lbpg_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  lbpg_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (s1_adv),
    .item_i    (s1_item_q),
    .cfg_i     (cfg),
    .res_o     (res),
    .state_o   (st)
  );

  assign out_o.valid           = out_valid_q;
  assign out_o.pin_level       = out_res_q.pin_level;
  assign out_o.pwm_active      = out_res_q.pwm_active;
  assign out_o.pwm_duty        = out_res_q.pwm_duty;
  assign out_o.current_pattern = out_res_q.current_pattern;
  assign out_o.is_enabled      = out_res_q.is_enabled;

  // Assertions.
  `ASSERT_SAME(a_pwm_pin_low, clk_i, rst_ni, out_o.valid && out_o.pwm_active, !out_o.pin_level, "pin driven while PWM active")
  `ASSERT_NEXT(a_adv_fills_out, clk_i, rst_ni, s1_adv, out_valid_q, "advanced command left no result")
  `ASSERT_NEXT(a_s1_hold, clk_i, rst_ni, s1_valid_q && !s1_adv, s1_valid_q, "pending command lost")
  `ASSERT_SAME(a_burst_dark, clk_i, rst_ni, st.burst_done, st.phase_count == '0 && !st.led_on, "finished burst not dark")

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED blink pattern generator testbench
// Drives command transfers with bursty timing and a stalling status receiver.
// A scoreboard predicts every status result from its own copy of the pattern
// state and the timing registers, and it compares each result field by field.
// The run covers zero, small and the largest timing values and both
// polarities.
// ----------------------------------------------------------------------------
module tb;
  import lbpg_pkg::*;

  localparam int unsigned CycleLimit  = 40_000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned LongHold    = 64;

  // Receiver stall behaviors.
  typedef enum int unsigned {
    RX_ALWAYS,
    RX_COIN,
    RX_MOSTLY,
    RX_ALTERNATE
  } rx_mode_e;

  // Predicts the status result of each accepted command and checks the results.
  class led_status_scoreboard;
    cfg_t        cfg;
    state_t      st;
    result_t     pending_status[$];
    int unsigned mismatches;

    function void restore_defaults();
      cfg.lit_high         = 1'b1;
      cfg.startup_pulse_ms = 16'd200;
      cfg.error_half_ms    = 16'd100;
      cfg.netfail_half_ms  = 16'd500;
      cfg.warning_half_ms  = 16'd200;
      cfg.alarm_half_ms    = 16'd50;
      st.pattern_reg       = PAT_OFF;
      st.led_on            = 1'b0;
      st.pwm_on            = 1'b0;
      st.duty_reg          = '0;
      st.enabled_reg       = 1'b1;
      st.phase_count       = '0;
      st.burst_done        = 1'b0;
      st.ms_since_toggle   = '0;
      pending_status.delete();
      mismatches = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [MsW-1:0] data);
      case (idx)
        CFG_LIT_HIGH:   cfg.lit_high         = data[0];
        CFG_STARTUP_MS: cfg.startup_pulse_ms = data;
        CFG_ERROR_MS:   cfg.error_half_ms    = data;
        CFG_NETFAIL_MS: cfg.netfail_half_ms  = data;
        CFG_WARNING_MS: cfg.warning_half_ms  = data;
        CFG_ALARM_MS:   cfg.alarm_half_ms    = data;
        default: ;
      endcase
    endfunction

    // A digital drive of the LED always takes the pin away from PWM.
    function void set_lamp(logic lit);
      st.led_on = lit;
      st.pwm_on = 1'b0;
    endfunction

    // Lit on an even phase, dark on an odd one; the phase wraps at eight.
    function void flip_on_parity();
      set_lamp(~st.phase_count[0]);
      st.phase_count     = st.phase_count + 1'b1;
      st.ms_since_toggle = '0;
    endfunction

    function void step_burst(logic [MsW-1:0] half, logic [PhW-1:0] phases);
      if (!st.burst_done && st.ms_since_toggle >= half) begin
        flip_on_parity();
        if (st.phase_count >= phases) begin
          st.phase_count = '0;
          st.burst_done  = 1'b1;
          set_lamp(1'b0);
        end
      end
    endfunction

    // The counter saturates whatever the pattern; blinking runs only when enabled.
    function void advance_ms();
      if (st.ms_since_toggle != MsMax) st.ms_since_toggle = st.ms_since_toggle + 1'b1;
      if (!st.enabled_reg) return;
      case (st.pattern_reg)
        PAT_STARTUP: begin
          if (st.phase_count == 3'd0) begin
            set_lamp(1'b1);
            st.ms_since_toggle = '0;
            st.phase_count     = 3'd1;
          end else if (st.phase_count == 3'd1 &&
                       st.ms_since_toggle >= cfg.startup_pulse_ms) begin
            set_lamp(1'b0);
            st.phase_count = 3'd2;
          end
        end
        PAT_ERROR:   step_burst(cfg.error_half_ms, ErrorPhases);
        PAT_WARNING: step_burst(cfg.warning_half_ms, WarningPhases);
        PAT_NET_FAIL: begin
          if (st.ms_since_toggle >= cfg.netfail_half_ms) flip_on_parity();
        end
        PAT_ALARM: begin
          if (st.ms_since_toggle >= cfg.alarm_half_ms) flip_on_parity();
        end
        default: ;
      endcase
    endfunction

    // Codes above the level pattern leave everything as it was.
    function void choose_pattern(logic [3:0] code);
      if (code > PAT_LEVEL) return;
      st.pattern_reg     = pattern_e'(code);
      st.phase_count     = '0;
      st.burst_done      = 1'b0;
      st.ms_since_toggle = '0;
      st.pwm_on          = 1'b0;
      case (pattern_e'(code))
        PAT_OFF, PAT_STATIC_OFF: set_lamp(1'b0);
        PAT_STATIC_ON, PAT_NET_OK: set_lamp(1'b1);
        PAT_NET_FAIL: begin
          set_lamp(1'b1);
          st.phase_count = 3'd1;
        end
        PAT_LEVEL: st.pwm_on = 1'b1;
        default: ;
      endcase
    endfunction

    function void note_command(item_t cmd);
      result_t r;
      case (cmd.operation)
        OP_TICK:   advance_ms();
        OP_SELECT: choose_pattern(cmd.pattern_code);
        OP_LEVEL: begin
          st.duty_reg = cmd.level_value;
          if (st.pattern_reg == PAT_LEVEL && st.enabled_reg) st.pwm_on = 1'b1;
        end
        default: begin
          st.enabled_reg = cmd.enable_value;
          if (!cmd.enable_value) set_lamp(1'b0);
        end
      endcase
      r.pin_level       = st.pwm_on ? 1'b0 :
                          (cfg.lit_high ? st.led_on : ~st.led_on);
      r.pwm_active      = st.pwm_on;
      r.pwm_duty        = st.duty_reg;
      r.current_pattern = st.pattern_reg;
      r.is_enabled      = st.enabled_reg;
      pending_status.push_back(r);
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] seen);
      if (seen !== want) begin
        $error("%s expected %0d got %0d", field, want, seen);
        mismatches++;
      end
    endfunction

    function void check_status(result_t got);
      result_t want;
      if (pending_status.size() == 0) begin
        $error("status transfer arrived with no result expected");
        mismatches++;
        return;
      end
      want = pending_status.pop_front();
      compare_field("pin_level", want.pin_level, got.pin_level);
      compare_field("pwm_active", want.pwm_active, got.pwm_active);
      compare_field("pwm_duty", want.pwm_duty, got.pwm_duty);
      compare_field("current_pattern", want.current_pattern, got.current_pattern);
      compare_field("is_enabled", want.is_enabled, got.is_enabled);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  lbpg_in_if  cmd_if ();
  lbpg_out_if status_if ();
  lbpg_cfg_if reg_if ();

  led_status_scoreboard board = new;
  item_t       cmd_q[$];
  int unsigned results_seen;

  led_blink_pattern_generator_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (status_if),
    .cfg_i  (reg_if)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run limit in case the block hangs.
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  // Status receiver: checks each transfer and stalls on its own pattern.
  initial begin
    int unsigned hold_left;
    int unsigned mode_left;
    rx_mode_e    rx_mode;
    hold_left    = 0;
    mode_left    = 0;
    rx_mode      = RX_ALWAYS;
    results_seen = 0;
    status_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && status_if.valid && status_if.ready) begin
        board.check_status('{pin_level:       status_if.pin_level,
                             pwm_active:      status_if.pwm_active,
                             pwm_duty:        status_if.pwm_duty,
                             current_pattern: status_if.current_pattern,
                             is_enabled:      status_if.is_enabled});
        results_seen++;
        // Long hold-offs let the block fill up and push back on commands.
        if (results_seen == 60 || results_seen == 300) hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        status_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 64);
        end
        mode_left--;
        case (rx_mode)
          RX_ALWAYS: status_if.ready <= 1'b1;
          RX_COIN:   status_if.ready <= 1'($urandom_range(0, 1));
          RX_MOSTLY: status_if.ready <= ($urandom_range(0, 5) != 0);
          default:   status_if.ready <= ~status_if.ready;
        endcase
      end
    end
  end

  function automatic item_t make_cmd(op_e op, logic [3:0] code, logic [7:0] lvl,
                                     logic en);
    item_t c;
    c.operation    = op;
    c.pattern_code = code;
    c.level_value  = lvl;
    c.enable_value = en;
    return c;
  endfunction

  // A command whose unused fields carry random values.
  function automatic item_t any_cmd(op_e op);
    return make_cmd(op, 4'($urandom), 8'($urandom), 1'($urandom));
  endfunction

  function automatic void queue_ticks(int unsigned n);
    repeat (n) cmd_q.push_back(any_cmd(OP_TICK));
  endfunction

  // One command transfer; valid stays high so back-to-back items need no gap.
  task automatic send_cmd(item_t c);
    cmd_if.valid        <= 1'b1;
    cmd_if.operation    <= c.operation;
    cmd_if.pattern_code <= c.pattern_code;
    cmd_if.level_value  <= c.level_value;
    cmd_if.enable_value <= c.enable_value;
    do @(posedge clk_i); while (!cmd_if.ready);
    board.note_command(c);
  endtask

  // Sends the queued commands in bursts with random gaps between them.
  task automatic send_queue();
    int unsigned burst;
    int unsigned gap;
    while (cmd_q.size() > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && cmd_q.size() > 0) begin
        send_cmd(cmd_q.pop_front());
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    cmd_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (board.pending_status.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [MsW-1:0] data);
    reg_if.valid <= 1'b1;
    reg_if.index <= idx;
    reg_if.data  <= data;
    do @(posedge clk_i); while (!reg_if.ready);
    reg_if.valid <= 1'b0;
    board.write_reg(idx, data);
  endtask

  // Rewrites every register once the block has gone idle.
  task automatic configure(logic polarity, int unsigned lo, int unsigned hi);
    wait_drained();
    write_reg(CFG_LIT_HIGH, {15'($urandom), polarity});
    write_reg(CFG_STARTUP_MS, 16'($urandom_range(lo, hi)));
    write_reg(CFG_ERROR_MS, 16'($urandom_range(lo, hi)));
    write_reg(CFG_NETFAIL_MS, 16'($urandom_range(lo, hi)));
    write_reg(CFG_WARNING_MS, 16'($urandom_range(lo, hi)));
    write_reg(CFG_ALARM_MS, 16'($urandom_range(lo, hi)));
  endtask

  // Mostly a pattern select followed by a random run of up to 48 ticks that may
  // finish the bursts, with level and enable writes mixed in; the rest is noise.
  task automatic build_random(int unsigned budget, int unsigned max_half);
    int unsigned made;
    int unsigned n;
    item_t       c;
    made = 0;
    while (made < budget) begin
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 4);
        repeat (n) cmd_q.push_back(any_cmd(op_e'($urandom_range(0, 3))));
        made += n;
      end else begin
        c = any_cmd(OP_SELECT);
        c.pattern_code = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15)) :
                                                        4'($urandom_range(0, 9));
        cmd_q.push_back(c);
        n = $urandom_range(1, 7 * (max_half + 1) + 2);
        if (n > 48) n = 48;
        repeat (n) begin
          case ($urandom_range(0, 19))
            0: cmd_q.push_back(any_cmd(OP_LEVEL));
            1: begin
              c = any_cmd(OP_ENABLE);
              c.enable_value = ($urandom_range(0, 3) != 0);
              cmd_q.push_back(c);
            end
            default: cmd_q.push_back(any_cmd(OP_TICK));
          endcase
        end
        made += n + 1;
      end
    end
  endtask

  // Main stimulus.
  initial begin
    cmd_if.valid        <= 1'b0;
    cmd_if.operation    <= OP_TICK;
    cmd_if.pattern_code <= '0;
    cmd_if.level_value  <= '0;
    cmd_if.enable_value <= 1'b0;
    reg_if.valid        <= 1'b0;
    reg_if.index        <= CFG_LIT_HIGH;
    reg_if.data         <= '0;
    rst_ni              <= 1'b0;
    board.restore_defaults();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every command, level mode enabled and disabled, unknown codes,
    // and every pattern select under the reset timing.
    cmd_q.push_back(make_cmd(OP_TICK, 4'hF, 8'hFF, 1'b1));
    cmd_q.push_back(make_cmd(OP_LEVEL, 4'h0, 8'hFF, 1'b0));
    cmd_q.push_back(make_cmd(OP_SELECT, PAT_LEVEL, 8'h00, 1'b0));
    cmd_q.push_back(make_cmd(OP_LEVEL, 4'hF, 8'h00, 1'b1));
    cmd_q.push_back(make_cmd(OP_ENABLE, 4'hF, 8'hFF, 1'b0));
    cmd_q.push_back(make_cmd(OP_LEVEL, 4'h0, 8'h80, 1'b0));
    cmd_q.push_back(make_cmd(OP_SELECT, PAT_LEVEL, 8'h55, 1'b1));
    cmd_q.push_back(make_cmd(OP_ENABLE, 4'h0, 8'h00, 1'b1));
    cmd_q.push_back(make_cmd(OP_SELECT, 4'hA, 8'hAA, 1'b0));
    cmd_q.push_back(make_cmd(OP_SELECT, 4'hF, 8'hFF, 1'b1));
    cmd_q.push_back(make_cmd(OP_SELECT, PAT_STATIC_ON, 8'h00, 1'b0));
    cmd_q.push_back(make_cmd(OP_SELECT, PAT_NET_OK, 8'h00, 1'b0));
    cmd_q.push_back(make_cmd(OP_SELECT, PAT_NET_FAIL, 8'h00, 1'b0));
    cmd_q.push_back(make_cmd(OP_SELECT, PAT_STATIC_OFF, 8'h00, 1'b0));
    cmd_q.push_back(make_cmd(OP_SELECT, PAT_OFF, 8'h00, 1'b0));
    cmd_q.push_back(make_cmd(OP_SELECT, PAT_STARTUP, 8'h00, 1'b0));
    cmd_q.push_back(make_cmd(OP_TICK, 4'h0, 8'h00, 1'b0));
    cmd_q.push_back(make_cmd(OP_SELECT, PAT_ERROR, 8'h00, 1'b0));
    cmd_q.push_back(make_cmd(OP_TICK, 4'h0, 8'h00, 1'b0));
    cmd_q.push_back(make_cmd(OP_SELECT, PAT_WARNING, 8'h00, 1'b0));
    cmd_q.push_back(make_cmd(OP_TICK, 4'h0, 8'h00, 1'b0));
    cmd_q.push_back(make_cmd(OP_SELECT, PAT_ALARM, 8'h00, 1'b0));
    cmd_q.push_back(make_cmd(OP_TICK, 4'h0, 8'h00, 1'b0));
    cmd_q.push_back(make_cmd(OP_ENABLE, 4'hF, 8'hFF, 1'b0));
    cmd_q.push_back(make_cmd(OP_ENABLE, 4'h0, 8'h00, 1'b1));
    send_queue();

    // Random phases over several timing settings, zero and one among them.
    configure(1'b1, 1, 6);
    build_random(100, 6);
    send_queue();
    configure(1'b0, 1, 1);
    build_random(90, 1);
    send_queue();
    configure(1'b1, 0, 0);
    build_random(80, 0);
    send_queue();
    configure(1'b0, 0, 10);
    build_random(110, 10);
    send_queue();

    // Largest timing: a short run of ticks never reaches a toggle point,
    // with a disabled stretch in between.
    configure(1'b1, 65535, 65535);
    cmd_q.push_back(make_cmd(OP_SELECT, PAT_ERROR, 8'h00, 1'b0));
    queue_ticks(6);
    cmd_q.push_back(make_cmd(OP_ENABLE, 4'h0, 8'h00, 1'b0));
    queue_ticks(4);
    cmd_q.push_back(make_cmd(OP_ENABLE, 4'h0, 8'h00, 1'b1));
    queue_ticks(2);
    cmd_q.push_back(make_cmd(OP_SELECT, PAT_STARTUP, 8'h00, 1'b0));
    queue_ticks(3);
    cmd_q.push_back(make_cmd(OP_SELECT, PAT_ALARM, 8'h00, 1'b0));
    queue_ticks(3);
    send_queue();

    configure(1'b1, 2, 5);
    build_random(100, 5);
    send_queue();

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending_status.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
